### hdl/rwe_pkg.sv
package rwe_pkg;

  localparam int DATA_BITS      = 24;
  localparam int PAR_BITS       = 6;
  localparam int WORD_BITS      = DATA_BITS + PAR_BITS;
  localparam int GROUP_BITS     = 6;
  localparam int BYTE_BITS      = 7;
  localparam int BYTES_PER_WORD = WORD_BITS / GROUP_BITS;

  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [GROUP_BITS-1:0] group_t;
  typedef logic [BYTE_BITS-1:0]  sbyte_t;
  typedef logic [2:0]            seq_t;
  typedef logic [2:0]            idx_t;

  localparam idx_t LAST_IDX = idx_t'(BYTES_PER_WORD - 1);

  // parity masks over the 30-bit word, data in bits 29..6
  localparam word_t MASK_D25 = 30'h3b1f3480;
  localparam word_t MASK_D26 = 30'h1d8f9a40;
  localparam word_t MASK_D27 = 30'h2ec7cd00;
  localparam word_t MASK_D28 = 30'h1763e680;
  localparam word_t MASK_D29 = 30'h2bb1f340;
  localparam word_t MASK_D30 = 30'h0b7a89c0;

  // queue write side and read side
  typedef struct packed {
    logic  push;
    word_t word;
  } q_wr_t;

  typedef struct packed {
    logic  avail;
    word_t word;
  } q_rd_t;

  // 0x40 marker with the 6-bit group bit-reversed
  function automatic sbyte_t make_byte(input group_t g);
    make_byte = {1'b1, g[0], g[1], g[2], g[3], g[4], g[5]};
  endfunction

endpackage

### hdl/rwe_channels.sv
interface rwe_in_if;
  import rwe_pkg::*;
  logic  valid;
  logic  ready;
  data_t data_bits;
  logic  stamp_sequence;

  modport source (output valid, output data_bits, output stamp_sequence, input ready);
  modport sink   (input valid, input data_bits, input stamp_sequence, output ready);
endinterface

interface rwe_out_if;
  import rwe_pkg::*;
  logic   valid;
  logic   ready;
  sbyte_t serial_byte;
  logic   last_byte;

  modport source (output valid, output serial_byte, output last_byte, input ready);
  modport sink   (input valid, input serial_byte, input last_byte, output ready);
endinterface

### hdl/rwe_front.sv
module rwe_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rwe_pkg::data_t in_data_bits,
  input  logic           in_stamp_sequence,
  input  logic           q_full,
  output rwe_pkg::q_wr_t q_wr
);
  import rwe_pkg::*;

  logic  prev_d29_r, prev_d29_nxt;
  logic  prev_d30_r, prev_d30_nxt;
  seq_t  seq_r, seq_nxt;
  data_t data_s;
  word_t w30;
  logic [PAR_BITS-1:0] par;
  data_t sent_data;
  logic  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    data_s = in_data_bits;
    if (in_stamp_sequence) begin
      data_s[10:8] = seq_r;
    end
    w30 = {data_s, {PAR_BITS{1'b0}}};
    par[5] = ^(w30 & MASK_D25) ^ prev_d29_r;
    par[4] = ^(w30 & MASK_D26) ^ prev_d30_r;
    par[3] = ^(w30 & MASK_D27) ^ prev_d29_r;
    par[2] = ^(w30 & MASK_D28) ^ prev_d30_r;
    par[1] = ^(w30 & MASK_D29) ^ prev_d30_r;
    par[0] = ^(w30 & MASK_D30) ^ prev_d29_r;
    // data goes out inverted after a word that ended with D30 set
    sent_data = prev_d30_r ? ~data_s : data_s;
  end

  assign q_wr.push = accept;
  assign q_wr.word = {sent_data, par};

  always_comb begin
    prev_d29_nxt = prev_d29_r;
    prev_d30_nxt = prev_d30_r;
    seq_nxt      = seq_r;
    if (accept) begin
      prev_d29_nxt = par[1];
      prev_d30_nxt = par[0];
      if (in_stamp_sequence) begin
        seq_nxt = seq_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_d29_r <= 1'b1;
      prev_d30_r <= 1'b1;
      seq_r      <= '0;
    end else begin
      prev_d29_r <= prev_d29_nxt;
      prev_d30_r <= prev_d30_nxt;
      seq_r      <= seq_nxt;
    end
  end

endmodule

### hdl/rwe_queue.sv
module rwe_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rwe_pkg::q_wr_t q_wr,
  output logic           q_full,
  output rwe_pkg::q_rd_t q_rd,
  input  logic           q_pop
);
  import rwe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  word_t            entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_full     = (count_r == CNT_FULL);
  assign q_rd.avail = (count_r != '0);
  assign q_rd.word  = entry_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_rd.avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/rwe_back.sv
module rwe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rwe_pkg::q_rd_t  q_rd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output rwe_pkg::sbyte_t out_serial_byte,
  output logic            out_last_byte
);
  import rwe_pkg::*;

  word_t  word_r, word_nxt;
  idx_t   idx_r, idx_nxt;
  logic   have_r, have_nxt;
  logic   out_valid_r, out_valid_nxt;
  sbyte_t byte_r, byte_nxt;
  logic   last_r, last_nxt;
  logic   adv;

  // output slot free or being drained this cycle
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !have_r && q_rd.avail;

  always_comb begin
    word_nxt      = word_r;
    idx_nxt       = idx_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    if (adv) begin
      if (have_r) begin
        out_valid_nxt = 1'b1;
        byte_nxt      = make_byte(word_r[WORD_BITS-1 -: GROUP_BITS]);
        last_nxt      = (idx_r == LAST_IDX);
        word_nxt      = word_r << GROUP_BITS;
        idx_nxt       = idx_r + 3'd1;
        have_nxt      = (idx_r != LAST_IDX);
      end else if (q_rd.avail) begin
        // first group goes straight from the queue head
        out_valid_nxt = 1'b1;
        byte_nxt      = make_byte(q_rd.word[WORD_BITS-1 -: GROUP_BITS]);
        last_nxt      = 1'b0;
        word_nxt      = q_rd.word << GROUP_BITS;
        idx_nxt       = 3'd1;
        have_nxt      = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) begin
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_serial_byte = byte_r;
  assign out_last_byte   = last_r;

endmodule

### hdl/rtcm2_word_encoder_unit.sv
// The first byte of a word passes through the queue and then the output byte register.
// Throughput: five bytes per word, one byte per cycle while out_ch.ready is high, set
// by the byte serializer in the back end; the front takes a word a cycle while the
// QUEUE_DEPTH-entry queue has room.
// Reset (rst_n, synchronous, active low): D29 = D30 = 1, sequence count 0,
// queue and output register empty.
module rtcm2_word_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  rwe_in_if.sink    in_ch,
  rwe_out_if.source out_ch
);
  import rwe_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  rwe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_bits      (in_ch.data_bits),
    .in_stamp_sequence (in_ch.stamp_sequence),
    .q_full            (q_full),
    .q_wr              (q_wr)
  );

  rwe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  rwe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_serial_byte (out_ch.serial_byte),
    .out_last_byte   (out_ch.last_byte)
  );

endmodule

### hdl/rwe_checker.sv
module rwe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] serial_byte,
  input logic       last_byte
);

  logic [2:0] pos_r;
  logic       out_acc;

  assign out_acc = out_valid && out_ready;

  // byte position within the current word, from the port side only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (out_acc) begin
      pos_r <= (pos_r == 3'd4) ? 3'd0 : pos_r + 3'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(serial_byte) && $stable(last_byte))
    else $error("stalled output transaction changed");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> serial_byte[6])
    else $error("byte marker bit missing");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (last_byte == (pos_r == 3'd4)))
    else $error("last byte flag out of place");

endmodule

bind rtcm2_word_encoder_unit rwe_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .serial_byte (out_ch.serial_byte),
  .last_byte   (out_ch.last_byte)
);

### dv/tb.sv
module tb;
  import rwe_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    data_t data;
    logic  stamp;
  } word_item_t;

  typedef struct {
    sbyte_t serial;
    logic   is_last;
  } out_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  rwe_in_if  in_ch ();
  rwe_out_if out_ch ();

  rtcm2_word_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  word_item_t tx_words[$];
  out_byte_t  expected_bytes[$];

  // encoder state mirror
  seq_t seq_count;
  logic last_d29;
  logic last_d30;

  logic tx_idle;
  logic rx_idle;
  logic hold_req;
  int   hold_left;
  int   tx_gap;
  int   rx_wait;
  int   stall_cycles;
  int   errors = 0;

  task report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Encode one data word into its five serial bytes and advance the state.
  task automatic encode_word(input data_t d, input logic stamp);
    data_t        src;
    word_t        w;
    word_t        sent;
    logic [5:0]   par;
    group_t       g;
    sbyte_t       b;
    out_byte_t    ob;
    src = d;
    if (stamp) begin
      src[10:8] = seq_count;
      seq_count = seq_count + 3'd1;
    end
    w = {src, 6'b0};
    // parity over the data before inversion
    par[5] = (^(w & MASK_D25)) ^ last_d29;
    par[4] = (^(w & MASK_D26)) ^ last_d30;
    par[3] = (^(w & MASK_D27)) ^ last_d29;
    par[2] = (^(w & MASK_D28)) ^ last_d30;
    par[1] = (^(w & MASK_D29)) ^ last_d30;
    par[0] = (^(w & MASK_D30)) ^ last_d29;
    sent = {(last_d30 ? ~src : src), par};
    last_d29 = par[1];
    last_d30 = par[0];
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      g = sent[WORD_BITS-1-GROUP_BITS*j -: GROUP_BITS];
      b[6] = 1'b1;
      for (int k = 0; k < GROUP_BITS; k++) b[k] = g[GROUP_BITS-1-k];
      ob.serial  = b;
      ob.is_last = (j == BYTES_PER_WORD - 1);
      expected_bytes.push_back(ob);
    end
  endtask

  // driver
  always @(posedge clk) begin
    word_item_t cur;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap      <= 0;
      seq_count    = '0;
      last_d29     = 1'b1;
      last_d30     = 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) encode_word(in_ch.data_bits, in_ch.stamp_sequence);
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          in_ch.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (tx_words.size() != 0) begin
          cur = tx_words.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.data_bits      <= cur.data;
          in_ch.stamp_sequence <= cur.stamp;
          tx_gap               <= tx_idle ? $urandom_range(0, 15) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    out_byte_t exp_b;
    int        nxt_wait;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h", out_ch.serial_byte));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_ch.serial_byte !== exp_b.serial)
            report($sformatf("serial_byte %02h, expected %02h",
                             out_ch.serial_byte, exp_b.serial));
          if (out_ch.last_byte !== exp_b.is_last)
            report($sformatf("last_byte %b, expected %b",
                             out_ch.last_byte, exp_b.is_last));
        end
        nxt_wait = rx_idle ? $urandom_range(0, 15) : 0;
      end else begin
        nxt_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait      <= nxt_wait;
      out_ch.ready <= (nxt_wait == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task push_word(input data_t d, input logic stamp);
    word_item_t it;
    it.data  = d;
    it.stamp = stamp;
    tx_words.push_back(it);
  endtask

  // Mostly framed messages (two header words then data words), some noise.
  task queue_random(input int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_word(data_t'($urandom), 1'($urandom));
        cnt++;
      end else begin
        len = $urandom_range(0, 6);
        push_word({8'h66, 16'($urandom)}, 1'b0);
        push_word(data_t'($urandom), 1'b1);
        for (int i = 0; i < len; i++) push_word(data_t'($urandom), 1'b0);
        cnt += len + 2;
      end
    end
  endtask

  task wait_drain();
    while (tx_words.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_bits      = '0;
    in_ch.stamp_sequence = 1'b0;
    out_ch.ready         = 1'b0;
    tx_idle              = 1'b1;
    rx_idle              = 1'b1;
    hold_req             = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, inversion from both seed states, counter wrap
    push_word(24'h000000, 1'b0);
    push_word(24'hffffff, 1'b0);
    push_word(24'hffffff, 1'b1);
    push_word(24'h000000, 1'b1);
    push_word(24'haaaaaa, 1'b0);
    push_word(24'h555555, 1'b1);
    push_word(24'h800000, 1'b0);
    push_word(24'h000001, 1'b0);
    push_word(24'h000700, 1'b1);  // stamped bits are overwritten
    push_word(24'hfff8ff, 1'b1);
    for (int i = 0; i < 6; i++) push_word(data_t'($urandom), 1'b1);  // wraps past 7
    push_word(24'h660000, 1'b0);
    push_word(24'h0007ff, 1'b1);
    wait_drain();

    // back-to-back, no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    queue_random(90);
    wait_drain();

    // receiver holds off while sender keeps offering
    queue_random(24);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_drain();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    queue_random(80);
    wait_drain();

    tx_idle = 1'b1;
    rx_idle = 1'b0;
    queue_random(30);
    wait_drain();

    tx_idle = 1'b0;
    rx_idle = 1'b1;
    queue_random(30);
    wait_drain();

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rwe_pkg.sv
hdl/rwe_channels.sv
hdl/rwe_front.sv
hdl/rwe_queue.sv
hdl/rwe_back.sv
hdl/rtcm2_word_encoder_unit.sv
hdl/rwe_checker.sv
dv/tb.sv
